// File: rtl/bfa_pkg.sv
// ----------------------------------------------------------------------------
// bfa_pkg: shared constants and helpers for the bitmap frame allocator
// Store geometry, operation codes, tally limits, the bit-count and saturating-add helpers.
// ----------------------------------------------------------------------------
package bfa_pkg;

	// number of frames tracked by the bitmap
	localparam int NUM_FRAMES = 65536;

	// bitmap row geometry
	localparam int WORD_W = 64;
	localparam int BIT_W  = $clog2(WORD_W);
	localparam int ROWS   = (NUM_FRAMES + WORD_W - 1) / WORD_W;
	localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;

	// frame arithmetic width: 20-bit first frame plus 21-bit count
	localparam int SUM_W  = 22;
	// wide row counter, so a scan can step past the last row
	localparam int RROW_W = SUM_W - BIT_W;

	// result field widths
	localparam int TALLY_W = 17;
	localparam int START_W = 16;
	localparam logic [TALLY_W-1:0] TALLY_MAX = {TALLY_W{1'b1}};

	// operation codes
	localparam logic [1:0] FUNC_ADD     = 2'd0;
	localparam logic [1:0] FUNC_RESERVE = 2'd1;
	localparam logic [1:0] FUNC_ALLOC   = 2'd2;
	localparam logic [1:0] FUNC_FREE    = 2'd3;

	// number of set bits in one bitmap row
	function automatic logic [BIT_W:0] row_popcount(input logic [WORD_W-1:0] w);
		logic [BIT_W:0] acc;
		acc = '0;
		for (int i = 0; i < WORD_W; i++) begin
			acc = acc + {{BIT_W{1'b0}}, w[i]};
		end
		return acc;
	endfunction

	// tally plus a row count, clamped at the tally maximum
	function automatic logic [TALLY_W-1:0] sat_add(input logic [TALLY_W-1:0] t,
			input logic [BIT_W:0] n);
		logic [TALLY_W:0] s;
		s = {1'b0, t} + {{(TALLY_W - BIT_W){1'b0}}, n};
		return s[TALLY_W] ? TALLY_MAX : s[TALLY_W-1:0];
	endfunction

endpackage

// File: rtl/bitmap_frame_allocator.sv
// ----------------------------------------------------------------------------
// bitmap_frame_allocator: first-fit page-frame allocator over a used bitmap
// Range add/reserve/free and run allocation on a row-wide bitmap memory.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel (req_valid/req_stall) carries func, first_frame and
//   frame_count; response channel (rsp_valid/rsp_stall) returns ok,
//   start_frame, frames_changed, used_count and total_count, one response
//   transaction per request transaction, in order.
// Timing:
//   One request is worked on at a time; req_stall is high until it ends.
//   Range operations read, modify and write back each 64-frame row touched.
//   Alloc scans rows from frame 0, stepping whole over a row that is fully
//   used or skippable as fully free and scanning a mixed row one bit per
//   cycle, then reads, modifies and writes back each row of the run found.
//   All bitmap work goes through one read-modify-write port and one shared
//   64-bit bit counter.
// Reset:
//   After arst_n releases, a clearing pass writes every row to all used,
//   one row at a time (1024 rows for 65536 frames), with req_stall held high.
// Stall:
//   The finished response sits in an output register; the next request is
//   accepted meanwhile and waits at completion until the register frees.
// ----------------------------------------------------------------------------
module bitmap_frame_allocator
	import bfa_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	// request channel
	input  logic                 req_valid,
	output logic                 req_stall,
	input  logic [1:0]           func,
	input  logic [19:0]          first_frame,
	input  logic [20:0]          frame_count,
	// response channel
	output logic                 rsp_valid,
	input  logic                 rsp_stall,
	output logic                 ok,
	output logic [START_W-1:0]   start_frame,
	output logic [TALLY_W-1:0]   frames_changed,
	output logic [TALLY_W-1:0]   used_count,
	output logic [TALLY_W-1:0]   total_count
);

	// sequencer state codes
	localparam logic [2:0] S_CLEAR = 3'd0; // post-reset fill with all used
	localparam logic [2:0] S_IDLE  = 3'd1; // waiting for a request
	localparam logic [2:0] S_RD    = 3'd2; // range op: read row
	localparam logic [2:0] S_MOD   = 3'd3; // range op: modify, write, count
	localparam logic [2:0] S_ARD   = 3'd4; // alloc scan: read row
	localparam logic [2:0] S_ACHK  = 3'd5; // alloc scan: whole-row check
	localparam logic [2:0] S_ABIT  = 3'd6; // alloc scan: one bit per cycle
	localparam logic [2:0] S_DONE  = 3'd7; // hand result to output register

	localparam logic [SUM_W-1:0] NUM_FRAMES_S = SUM_W'(NUM_FRAMES);
	localparam logic [SUM_W-1:0] WORD_S       = SUM_W'(WORD_W);
	localparam logic [BIT_W-1:0] BIT_LAST     = BIT_W'(WORD_W - 1);
	localparam logic [ROW_W-1:0] ROW_LAST     = ROW_W'(ROWS - 1);

	// bitmap memory
	logic [WORD_W-1:0] mem [ROWS];
	logic [WORD_W-1:0] rd_q;
	logic              mem_we;
	logic              mem_re;
	logic [ROW_W-1:0]  mem_waddr;
	logic [WORD_W-1:0] mem_wdata;

	// control state
	logic [2:0]         state_q;
	logic [ROW_W-1:0]   clr_q;
	logic [TALLY_W-1:0] used_q;
	logic [TALLY_W-1:0] usable_q;
	logic               rsp_valid_q;

	// working registers of the current transaction
	logic [1:0]         func_q;
	logic [SUM_W-1:0]   first_q;
	logic [SUM_W-1:0]   end_q;
	logic [SUM_W-1:0]   count_q;
	logic [SUM_W-1:0]   limit_q;
	logic [SUM_W-1:0]   run_q;
	logic [RROW_W-1:0]  row_q;
	logic [BIT_W-1:0]   bit_q;
	logic [TALLY_W-1:0] changed_q;
	logic               ok_q;
	logic [START_W-1:0] start_q;

	// response payload
	logic               rsp_ok_q;
	logic [START_W-1:0] rsp_start_q;
	logic [TALLY_W-1:0] rsp_changed_q;
	logic [TALLY_W-1:0] rsp_used_q;
	logic [TALLY_W-1:0] rsp_total_q;

	// request decode
	logic             req_fire;
	logic [SUM_W-1:0] first_ext;
	logic [SUM_W-1:0] count_ext;
	logic [SUM_W-1:0] end_sum;
	logic [SUM_W-1:0] end_clip;
	logic [SUM_W-1:0] limit_w;

	assign req_stall = (state_q != S_IDLE);
	assign req_fire  = req_valid && !req_stall;
	assign first_ext = {{(SUM_W - 20){1'b0}}, first_frame};
	assign count_ext = {{(SUM_W - 21){1'b0}}, frame_count};
	assign end_sum   = first_ext + count_ext;
	assign end_clip  = (end_sum > NUM_FRAMES_S) ? NUM_FRAMES_S : end_sum;
	assign limit_w   = ({{(SUM_W - TALLY_W){1'b0}}, usable_q} < NUM_FRAMES_S)
		? {{(SUM_W - TALLY_W){1'b0}}, usable_q} : NUM_FRAMES_S;

	// row datapath
	logic [SUM_W-1:0]  base;
	logic [SUM_W-1:0]  endm1;
	logic [BIT_W-1:0]  lo_off;
	logic [BIT_W-1:0]  hi_off;
	logic [WORD_W-1:0] mask;
	logic [WORD_W-1:0] pop_src;
	logic [WORD_W-1:0] new_word;
	logic [BIT_W:0]    pop;
	logic              row_is_last;
	logic [SUM_W-1:0]  frame_f;
	logic [SUM_W-1:0]  run_inc;
	logic [SUM_W-1:0]  run_start;

	assign base        = {row_q, {BIT_W{1'b0}}};
	assign endm1       = end_q - SUM_W'(1);
	assign row_is_last = (row_q == endm1[SUM_W-1:BIT_W]);
	assign lo_off      = (row_q == first_q[SUM_W-1:BIT_W]) ? first_q[BIT_W-1:0] : '0;
	assign hi_off      = row_is_last ? endm1[BIT_W-1:0] : BIT_LAST;
	assign mask        = ({WORD_W{1'b1}} << lo_off) & ({WORD_W{1'b1}} >> (BIT_LAST - hi_off));
	assign frame_f     = base + {{(SUM_W - BIT_W){1'b0}}, bit_q};
	assign run_inc     = run_q + SUM_W'(1);
	assign run_start   = frame_f + SUM_W'(1) - count_q;

	always_comb begin
		unique case (func_q)
			FUNC_ADD: begin
				new_word = rd_q & ~mask;
				pop_src  = mask;
			end
			FUNC_FREE: begin
				new_word = rd_q & ~mask;
				pop_src  = rd_q & mask;
			end
			default: begin
				// reserve, and marking of a found alloc run
				new_word = rd_q | mask;
				pop_src  = ~rd_q & mask;
			end
		endcase
	end

	// the one shared bit counter
	assign pop = row_popcount(pop_src);

	// memory port control
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = row_q[ROW_W-1:0];
		mem_wdata = new_word;
		mem_re    = (state_q == S_RD) || (state_q == S_ARD && base < limit_q);
		if (state_q == S_CLEAR) begin
			mem_we    = 1'b1;
			mem_waddr = clr_q;
			mem_wdata = {WORD_W{1'b1}};
		end else if (state_q == S_MOD) begin
			mem_we = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			rd_q <= mem[row_q[ROW_W-1:0]];
		end
	end

	// sequencer and tallies
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_q       <= '0;
			used_q      <= '0;
			usable_q    <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			// output register: load on completion, drop when taken
			if (state_q == S_DONE && (!rsp_valid_q || !rsp_stall)) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + ROW_W'(1);
					if (clr_q == ROW_LAST) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (req_fire) begin
						if (func == FUNC_ALLOC) begin
							if (count_ext == '0 || count_ext > limit_w) begin
								state_q <= S_DONE;
							end else begin
								state_q <= S_ARD;
							end
						end else if (first_ext >= end_clip) begin
							state_q <= S_DONE;
						end else begin
							state_q <= S_RD;
						end
					end
				end
				S_RD: begin
					state_q <= S_MOD;
				end
				S_MOD: begin
					unique case (func_q)
						FUNC_ADD: usable_q <= sat_add(usable_q, pop);
						FUNC_FREE: begin
							if (used_q > {{(TALLY_W - BIT_W - 1){1'b0}}, pop}) begin
								used_q <= used_q - {{(TALLY_W - BIT_W - 1){1'b0}}, pop};
							end else begin
								used_q <= '0;
							end
						end
						default: used_q <= sat_add(used_q, pop);
					endcase
					state_q <= row_is_last ? S_DONE : S_RD;
				end
				S_ARD: begin
					state_q <= (base >= limit_q) ? S_DONE : S_ACHK;
				end
				S_ACHK: begin
					priority if (&rd_q) begin
						state_q <= S_ARD;
					end else if (rd_q == '0 && base + WORD_S <= limit_q
							&& run_q + WORD_S < count_q) begin
						state_q <= S_ARD;
					end else begin
						state_q <= S_ABIT;
					end
				end
				S_ABIT: begin
					priority if (frame_f >= limit_q) begin
						state_q <= S_DONE;
					end else if (!rd_q[bit_q] && run_inc == count_q) begin
						state_q <= S_RD;
					end else if (bit_q == BIT_LAST) begin
						state_q <= S_ARD;
					end else begin
						state_q <= S_ABIT;
					end
				end
				S_DONE: begin
					if (!rsp_valid_q || !rsp_stall) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// working registers and response payload
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (req_fire) begin
					func_q    <= func;
					first_q   <= first_ext;
					end_q     <= end_clip;
					count_q   <= count_ext;
					limit_q   <= limit_w;
					run_q     <= '0;
					row_q     <= (func == FUNC_ALLOC) ? '0 : first_ext[SUM_W-1:BIT_W];
					changed_q <= '0;
					start_q   <= '0;
					ok_q      <= !(func == FUNC_ALLOC
						&& (count_ext == '0 || count_ext > limit_w));
				end
			end
			S_MOD: begin
				changed_q <= sat_add(changed_q, pop);
				row_q     <= row_q + RROW_W'(1);
			end
			S_ARD: begin
				if (base >= limit_q) begin
					ok_q <= 1'b0;
				end
			end
			S_ACHK: begin
				bit_q <= '0;
				priority if (&rd_q) begin
					run_q <= '0;
					row_q <= row_q + RROW_W'(1);
				end else if (rd_q == '0 && base + WORD_S <= limit_q
						&& run_q + WORD_S < count_q) begin
					run_q <= run_q + WORD_S;
					row_q <= row_q + RROW_W'(1);
				end else begin
					run_q <= run_q;
				end
			end
			S_ABIT: begin
				priority if (frame_f >= limit_q) begin
					ok_q <= 1'b0;
				end else if (!rd_q[bit_q] && run_inc == count_q) begin
					// run found: mark [start, f] as a set operation
					first_q <= run_start;
					end_q   <= frame_f + SUM_W'(1);
					start_q <= run_start[START_W-1:0];
					row_q   <= run_start[SUM_W-1:BIT_W];
				end else begin
					run_q <= rd_q[bit_q] ? '0 : run_inc;
					bit_q <= bit_q + BIT_W'(1);
					if (bit_q == BIT_LAST) begin
						row_q <= row_q + RROW_W'(1);
					end
				end
			end
			S_DONE: begin
				if (!rsp_valid_q || !rsp_stall) begin
					rsp_ok_q      <= ok_q;
					rsp_start_q   <= ok_q ? start_q : '0;
					rsp_changed_q <= ok_q ? changed_q : '0;
					rsp_used_q    <= used_q;
					rsp_total_q   <= usable_q;
				end
			end
			default: begin
				rsp_ok_q <= rsp_ok_q;
			end
		endcase
	end

	assign rsp_valid      = rsp_valid_q;
	assign ok             = rsp_ok_q;
	assign start_frame    = rsp_start_q;
	assign frames_changed = rsp_changed_q;
	assign used_count     = rsp_used_q;
	assign total_count    = rsp_total_q;

`ifndef ASSERT_OFF
	// a failed alloc reports no start and no changed frames
	a_fail_clean: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !ok |-> start_frame == '0 && frames_changed == '0)
		else $error("failed alloc returned nonzero start or count");

	// a range pass never runs past the last row of its range
	a_row_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_MOD |-> row_q <= endm1[SUM_W-1:BIT_W])
		else $error("range pass beyond end row");

	// an accepted request always leaves the idle state
	a_leave_idle: assert property (@(posedge clk) disable iff (!arst_n)
		req_fire |=> state_q != S_IDLE)
		else $error("request accepted but sequencer stayed idle");

	// the free-run counter stays short of the requested length while scanning
	a_run_short: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_ABIT |-> run_q < count_q)
		else $error("scan run counter reached request length");
`endif

endmodule

// File: bench/bitmap_frame_allocator_test.sv
// ----------------------------------------------------------------------------
// bitmap_frame_allocator_test: self-checking bench for the frame allocator
// Runs a table of directed transactions, then random range and alloc traffic
// with random idling on both channels. Every response is checked field by
// field against its typed reply or a bit-level shadow of the used bitmap and both tallies.
// ----------------------------------------------------------------------------
module bitmap_frame_allocator_test;
	import bfa_pkg::*;

	localparam int unsigned N_RANDOM    = 1500;
	// most random traffic lands in the low frames, so the bitmap stays mixed
	// there while the rows above stay uniform and cheap to scan
	localparam int unsigned WINDOW      = 1024;
	localparam int unsigned LONG_HOLD   = 400;
	localparam int unsigned TAIL_CYCLES = 200;
	localparam logic [19:0] FIRST_MAX   = 20'hFFFFF;
	localparam logic [20:0] COUNT_MAX   = 21'h1FFFFF;
	localparam logic [20:0] COUNT_TOP   = 21'h100000;
	// worst alloc: every row mixed and scanned bit by bit, then a full marking
	// pass, plus both sides idling their longest
	localparam longint ITEM_WORST = longint'(ROWS) * (WORD_W + 4) + 2 * 8 + 4;
	localparam longint RUN_LIMIT  = 4 * (ROWS + (N_RANDOM + 30) * ITEM_WORST);

	typedef struct packed {
		logic               ok;
		logic [START_W-1:0] start;
		logic [TALLY_W-1:0] changed;
		logic [TALLY_W-1:0] used;
		logic [TALLY_W-1:0] total;
	} frame_reply_t;

	typedef struct {
		logic [1:0]   op;
		logic [19:0]  lo;
		logic [20:0]  cnt;
		bit           typed;   // reply typed into the table, not predicted
		frame_reply_t reply;
	} frame_req_t;

	// block ports, all inputs known from time zero
	logic               clk         = 1'b0;
	logic               arst_n      = 1'b0;
	logic               req_valid   = 1'b0;
	logic               req_stall;
	logic [1:0]         func        = FUNC_ADD;
	logic [19:0]        first_frame = '0;
	logic [20:0]        frame_count = '0;
	logic               rsp_valid;
	logic               rsp_stall   = 1'b0;
	logic               ok;
	logic [START_W-1:0] start_frame;
	logic [TALLY_W-1:0] frames_changed;
	logic [TALLY_W-1:0] used_count;
	logic [TALLY_W-1:0] total_count;

	// shadow of the allocator: one used bit per frame and both tallies
	bit                 shadow_used [NUM_FRAMES];
	logic [TALLY_W-1:0] shadow_in_use;
	logic [TALLY_W-1:0] shadow_usable;

	frame_reply_t replies_owed [$];   // replies still due, oldest first
	frame_req_t   directed_rows [$];
	int unsigned  mismatches   = 0;
	int unsigned  replies_seen = 0;
	longint       cycles       = 0;
	bit           quiet_tx     = 1'b0;   // stretch with no sender idling
	bit           quiet_rx     = 1'b0;   // stretch with no receiver stalls

	bitmap_frame_allocator DUT (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.func(func),
		.first_frame(first_frame),
		.frame_count(frame_count),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.ok(ok),
		.start_frame(start_frame),
		.frames_changed(frames_changed),
		.used_count(used_count),
		.total_count(total_count)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > RUN_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	function automatic logic [TALLY_W-1:0] tally_up(input logic [TALLY_W-1:0] v);
		return (v == TALLY_MAX) ? v : v + 1'b1;
	endfunction

	// Apply one transaction to the shadow and return the reply it must give.
	// Range ops clip at the store end; frames past it are never touched.
	function automatic frame_reply_t apply_frame_op(input logic [1:0] op,
			input logic [19:0] lo, input logic [20:0] cnt);
		frame_reply_t r;
		int unsigned  stop, f, limit, run, hit;
		bit           found;
		r     = '0;
		r.ok  = 1'b1;
		run   = 0;
		hit   = 0;
		found = 1'b0;
		stop  = int'(lo) + int'(cnt);
		if (stop > NUM_FRAMES) stop = NUM_FRAMES;
		case (op)
			FUNC_ADD: begin
				// counted into the total even when already free
				for (f = lo; f < stop; f++) begin
					shadow_used[f] = 1'b0;
					shadow_usable  = tally_up(shadow_usable);
					r.changed      = tally_up(r.changed);
				end
			end
			FUNC_RESERVE: begin
				for (f = lo; f < stop; f++) begin
					if (!shadow_used[f]) begin
						shadow_used[f] = 1'b1;
						shadow_in_use  = tally_up(shadow_in_use);
						r.changed      = tally_up(r.changed);
					end
				end
			end
			FUNC_FREE: begin
				// the used tally floors at zero
				for (f = lo; f < stop; f++) begin
					if (shadow_used[f]) begin
						shadow_used[f] = 1'b0;
						if (shadow_in_use != 0) shadow_in_use = shadow_in_use - 1'b1;
						r.changed = tally_up(r.changed);
					end
				end
			end
			FUNC_ALLOC: begin
				// first fit from frame 0, wholly below min(total, store size)
				limit = (shadow_usable < NUM_FRAMES) ? shadow_usable : NUM_FRAMES;
				r.ok  = 1'b0;
				if (cnt != 0 && cnt <= limit) begin
					for (f = 0; f < limit && !found; f++) begin
						if (shadow_used[f]) begin
							run = 0;
						end else begin
							run++;
							if (run == cnt) begin
								hit   = f + 1 - cnt;
								found = 1'b1;
							end
						end
					end
				end
				if (found) begin
					for (f = hit; f < hit + cnt; f++) begin
						shadow_used[f] = 1'b1;
						shadow_in_use  = tally_up(shadow_in_use);
						r.changed      = tally_up(r.changed);
					end
					r.ok    = 1'b1;
					r.start = START_W'(hit);
				end
			end
		endcase
		r.used  = shadow_in_use;
		r.total = shadow_usable;
		return r;
	endfunction

	// table row checked against the shadow
	task automatic row(input logic [1:0] op, input int unsigned lo, input int unsigned cnt);
		frame_req_t rq;
		rq.op    = op;
		rq.lo    = 20'(lo);
		rq.cnt   = 21'(cnt);
		rq.typed = 1'b0;
		rq.reply = '0;
		directed_rows.push_back(rq);
	endtask

	// table row with its reply typed in
	task automatic row_chk(input logic [1:0] op, input int unsigned lo,
			input int unsigned cnt, input bit k, input int unsigned s,
			input int unsigned c, input int unsigned u, input int unsigned t);
		frame_req_t rq;
		rq.op            = op;
		rq.lo            = 20'(lo);
		rq.cnt           = 21'(cnt);
		rq.typed         = 1'b1;
		rq.reply.ok      = k;
		rq.reply.start   = START_W'(s);
		rq.reply.changed = TALLY_W'(c);
		rq.reply.used    = TALLY_W'(u);
		rq.reply.total   = TALLY_W'(t);
		directed_rows.push_back(rq);
	endtask

	// Offer one request and hold it until accepted. The shadow moves at
	// the accepting edge, so replies queue in request order.
	task automatic send_req(input frame_req_t rq);
		frame_reply_t pred;
		req_valid   <= 1'b1;
		func        <= rq.op;
		first_frame <= rq.lo;
		frame_count <= rq.cnt;
		@(posedge clk);
		while (req_stall !== 1'b0) @(posedge clk);
		pred = apply_frame_op(rq.op, rq.lo, rq.cnt);
		replies_owed.push_back(rq.typed ? rq.reply : pred);
	endtask

	// Sender idling before a request; drain waits out every owed reply.
	// With no gap, valid stays high straight into the next request.
	task automatic pause_tx(input bit drain);
		int unsigned gap;
		gap = quiet_tx ? 0 : $urandom_range(0, 8);
		if (drain) begin
			req_valid <= 1'b0;
			@(posedge clk);
			while (replies_owed.size() != 0) @(posedge clk);
		end else if (gap != 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Random request: mostly short ranges and small runs in the low window,
	// a few wide ones, some with full-width fields.
	task automatic draw_req(output frame_req_t rq);
		int unsigned roll;
		rq.typed = 1'b0;
		rq.reply = '0;
		roll     = $urandom_range(0, 99);
		if (roll < 5) begin
			rq.op = 2'($urandom_range(0, 3));
			case ($urandom_range(0, 2))
				0: begin
					rq.lo  = 20'($urandom);
					rq.cnt = 21'($urandom);
				end
				1: begin
					rq.lo  = 20'($urandom_range(0, NUM_FRAMES - 1));
					rq.cnt = 21'($urandom_range(0, NUM_FRAMES + 4096));
				end
				default: begin
					rq.lo  = 20'($urandom_range(0, WINDOW - 1));
					rq.cnt = 21'($urandom_range(0, 3000));
				end
			endcase
		end else begin
			roll = $urandom_range(0, 99);
			if (roll < 12) rq.op = FUNC_ADD;
			else if (roll < 37) rq.op = FUNC_RESERVE;
			else if (roll < 72) rq.op = FUNC_ALLOC;
			else rq.op = FUNC_FREE;
			rq.lo  = 20'($urandom_range(0, WINDOW - 1));
			rq.cnt = ($urandom_range(0, 9) == 0) ? 21'($urandom_range(0, 300))
					: 21'($urandom_range(0, 24));
		end
	endtask

	task automatic flag_error(input string msg);
		mismatches++;
		$display("reply %0d: %s", replies_seen, msg);
	endtask

	task automatic check_reply();
		frame_reply_t want;
		if (replies_owed.size() == 0) begin
			flag_error("reply with no request outstanding");
			return;
		end
		want = replies_owed.pop_front();
		if (ok !== want.ok)
			flag_error($sformatf("ok %0d, want %0d", ok, want.ok));
		if (start_frame !== want.start)
			flag_error($sformatf("start_frame %0d, want %0d", start_frame, want.start));
		if (frames_changed !== want.changed)
			flag_error($sformatf("frames_changed %0d, want %0d", frames_changed,
					want.changed));
		if (used_count !== want.used)
			flag_error($sformatf("used_count %0d, want %0d", used_count, want.used));
		if (total_count !== want.total)
			flag_error($sformatf("total_count %0d, want %0d", total_count, want.total));
	endtask

	// Receiver: random stall before each reply, two long holds that back the
	// block up until it stalls its request side.
	initial begin : rsp_side
		int unsigned hold;
		forever begin
			if (replies_seen % 48 == 0) quiet_rx = ($urandom_range(0, 3) == 0);
			hold = quiet_rx ? 0 : $urandom_range(0, 8);
			if (replies_seen == 300 || replies_seen == 1100) hold = LONG_HOLD;
			if (hold != 0) begin
				rsp_stall <= 1'b1;
				repeat (hold) @(posedge clk);
			end
			rsp_stall <= 1'b0;
			@(posedge clk);
			while (rsp_valid !== 1'b1) @(posedge clk);
			replies_seen++;
			check_reply();
		end
	end

	initial begin : stimulus
		frame_req_t  rq;
		int unsigned n;
		foreach (shadow_used[i]) shadow_used[i] = 1'b1;
		shadow_in_use = '0;
		shadow_usable = '0;

		//      op            first            count            ok start changed  used  total
		// out of reset nothing is usable, every frame is used, tallies are zero
		row_chk(FUNC_ALLOC,   0,               1,               0, 0, 0,          0, 0);
		row_chk(FUNC_FREE,    0,               0,               1, 0, 0,          0, 0);
		row_chk(FUNC_RESERVE, 0,               64,              1, 0, 0,          0, 0);
		// freeing with the used tally at zero keeps it at zero
		row_chk(FUNC_FREE,    0,               16,              1, 0, 16,         0, 0);
		// past the store, and a range clipped at the last frame
		row_chk(FUNC_ADD,     FIRST_MAX,       1,               1, 0, 0,          0, 0);
		row_chk(FUNC_ADD,     NUM_FRAMES - 1,  COUNT_MAX,       1, 0, 1,          0, 1);
		// whole store twice: counted again, total saturates
		row_chk(FUNC_ADD,     0,               COUNT_TOP,       1, 0, NUM_FRAMES, 0,
				NUM_FRAMES + 1);
		row_chk(FUNC_ADD,     0,               COUNT_TOP,       1, 0, NUM_FRAMES, 0,
				TALLY_MAX);
		// empty run and oversized run fail
		row_chk(FUNC_ALLOC,   0,               0,               0, 0, 0,          0,
				TALLY_MAX);
		row_chk(FUNC_ALLOC,   0,               NUM_FRAMES + 1,  0, 0, 0,          0,
				TALLY_MAX);
		row_chk(FUNC_ALLOC,   0,               NUM_FRAMES,      1, 0, NUM_FRAMES,
				NUM_FRAMES, TALLY_MAX);
		row_chk(FUNC_FREE,    0,               COUNT_TOP,       1, 0, NUM_FRAMES, 0,
				TALLY_MAX);
		row_chk(FUNC_ALLOC,   0,               1,               1, 0, 1,          1,
				TALLY_MAX);
		row_chk(FUNC_ALLOC,   0,               5,               1, 1, 5,          6,
				TALLY_MAX);
		row_chk(FUNC_RESERVE, 10,              3,               1, 0, 3,          9,
				TALLY_MAX);
		// first fit into holes, first_frame ignored by alloc
		row(FUNC_ALLOC,   0,              4);
		row(FUNC_FREE,    1,              3);
		row(FUNC_ALLOC,   FIRST_MAX,      2);
		row(FUNC_RESERVE, NUM_FRAMES - 6, 100);
		// run landing high in the store, then a full-width count
		row(FUNC_RESERVE, 0,              65000);
		row(FUNC_ALLOC,   0,              500);
		row(FUNC_ALLOC,   FIRST_MAX,      COUNT_MAX);
		// used tally driven past its maximum: reserve, re-add, reserve again
		row(FUNC_RESERVE, 0,              COUNT_TOP);
		row(FUNC_ADD,     0,              COUNT_TOP);
		row(FUNC_RESERVE, 0,              COUNT_TOP);
		// leave the store all free for the random traffic
		row(FUNC_ADD,     0,              COUNT_TOP);

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// the block holds req_stall through its clearing pass
		foreach (directed_rows[i]) begin
			pause_tx(1'b0);
			send_req(directed_rows[i]);
		end

		for (n = 0; n < N_RANDOM; n++) begin
			if (n % 64 == 0) quiet_tx = ($urandom_range(0, 3) == 0);
			pause_tx(n == N_RANDOM / 2);
			draw_req(rq);
			send_req(rq);
		end
		req_valid <= 1'b0;

		while (replies_owed.size() != 0) @(posedge clk);
		// catch any stray reply after the last one due
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0) $display("Simulation PASSED");
		else $display("Simulation FAILED");
		$finish;
	end

endmodule

// File: sim.f
rtl/bfa_pkg.sv
rtl/bitmap_frame_allocator.sv
bench/bitmap_frame_allocator_test.sv
